// File: rtl/core/audio_clock_format_detector_defines.svh
// ---------------------------------------------------------------------------
// audio clock format detector assertion macros
// concurrent assertion helpers shared by the detector rtl
// ---------------------------------------------------------------------------
`ifndef AUDIO_CLOCK_FORMAT_DETECTOR_DEFINES_SVH
`define AUDIO_CLOCK_FORMAT_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge outside reset
`define ACFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must be followed by an outcome in the next cycle
`define ACFD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ACFD_ASSERT(lbl, clk, rst, prop, msg)
`define ACFD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)

`endif

`endif

// File: rtl/core/acfd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acfd_pkg
// widths, standard rates, register map and sequencer states of the
// audio clock format detector
// ---------------------------------------------------------------------------
package acfd_pkg;

   // field widths
   localparam int COUNT_W  = 24;
   localparam int RATE_W   = 19;
   localparam int DEPTH_W  = 6;
   localparam int TOL_W    = 12;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // tolerance is in units of 2^-20 of the nominal rate
   localparam int PPM_SHIFT = 20;
   localparam int DEV_W     = RATE_W + TOL_W - PPM_SHIFT;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(250);

   // register indexes
   localparam logic CSR_TOLERANCE = 1'b0;

   // standard rates, tried in this order
   localparam int NUM_STD_RATES = 8;
   localparam int RATE_IDX_W    = 3;
   localparam logic [RATE_W-1:0] STD_RATE [NUM_STD_RATES] = '{
      RATE_W'(384000), RATE_W'(352800), RATE_W'(192000), RATE_W'(176400),
      RATE_W'(96000),  RATE_W'(88200),  RATE_W'(48000),  RATE_W'(44100)
   };

   // recognized slot depths
   localparam logic [DEPTH_W-1:0] DEPTH_NONE = DEPTH_W'(0);
   localparam logic [DEPTH_W-1:0] DEPTH_16   = DEPTH_W'(16);
   localparam logic [DEPTH_W-1:0] DEPTH_24   = DEPTH_W'(24);
   localparam logic [DEPTH_W-1:0] DEPTH_32   = DEPTH_W'(32);

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_CHECK     = 6'b000010,
      ST_DIV_RATE  = 6'b000100,
      ST_DIV_DEPTH = 6'b001000,
      ST_SNAP      = 6'b010000,
      ST_FINISH    = 6'b100000
   } state_type;

   // rates derived from a 48 khz base
   function automatic logic is_family_48k(input logic [RATE_W-1:0] rate);
      return (rate == RATE_W'(48000)) || (rate == RATE_W'(96000)) ||
             (rate == RATE_W'(192000)) || (rate == RATE_W'(384000));
   endfunction

endpackage

// File: rtl/core/audio_clock_format_detector.sv
`timescale 1ns / 1ps
`include "audio_clock_format_detector_defines.svh"
// ---------------------------------------------------------------------------
// audio_clock_format_detector
// recognizes sample rate and slot depth from word and bit clock counts
// ---------------------------------------------------------------------------
// One transaction per measurement pair. A pair within one tick of the stored
// pair while the format is valid, or a pair with a zero count, goes from the
// check state to the finish state, which loads the response register. Any
// other pair runs one restoring divider (DIV_BITS wide, 31 at the default
// parameters), one quotient bit per cycle, twice, first for the sample rate
// and then for the word/bit count ratio, followed by a compare against the
// standard rates one per cycle. A response held by rsp_stall delays the load.
// req_stall stays high from acceptance until the result is loaded into the
// output register; the next request can be taken once the sequencer is back
// in idle, and a result waiting on rsp_stall does not block it.
// tolerance_ppm is written at byte address 0 of the csr port.
// ---------------------------------------------------------------------------
module audio_clock_format_detector #(
   parameter int CLOCK_HZ    = 125000000,
   parameter int WORD_WINDOW = 24,
   parameter int BIT_RATIO   = 32,
   parameter int COUNT_BITS  = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [acfd_pkg::COUNT_W-1:0]   req_word_clock_count,
   input  logic [acfd_pkg::COUNT_W-1:0]   req_bit_clock_count,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_stream_valid,
   output logic [acfd_pkg::RATE_W-1:0]    rsp_sample_rate_hz,
   output logic [acfd_pkg::DEPTH_W-1:0]   rsp_frame_bit_depth,
   output logic                           rsp_lock_pulse,
   output logic                           rsp_family_48k,
   // csr port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [acfd_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [acfd_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [acfd_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);
   import acfd_pkg::*;

   // divider sizing
   localparam logic [63:0] RATE_NUM = 64'(CLOCK_HZ / 2) * 64'(WORD_WINDOW);
   localparam int RATE_NUM_W  = $clog2(RATE_NUM + 64'd1);
   localparam int RATIO_NUM_W = $clog2(BIT_RATIO + 1) + COUNT_W;
   localparam int DIV_BITS    = (RATE_NUM_W > RATIO_NUM_W) ? RATE_NUM_W : RATIO_NUM_W;
   localparam int STEP_W      = $clog2(DIV_BITS + 1);
   localparam int CMP_W       = DIV_BITS + 1;
   localparam int MASK_W      = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
   localparam logic [COUNT_W-1:0] COUNT_MASK = {COUNT_W{1'b1}} >> (COUNT_W - MASK_W);

   // registers
   state_type              state_ff,        state_in;
   logic [COUNT_W-1:0]     wc_ff,           wc_in;
   logic [COUNT_W-1:0]     bc_ff,           bc_in;
   logic [COUNT_W-1:0]     last_wc_ff,      last_wc_in;
   logic [COUNT_W-1:0]     last_bc_ff,      last_bc_in;
   logic [RATE_W-1:0]      held_rate_ff,    held_rate_in;
   logic [DEPTH_W-1:0]     held_depth_ff,   held_depth_in;
   logic                   held_valid_ff,   held_valid_in;
   logic [TOL_W-1:0]       tol_ff,          tol_in;
   logic [COUNT_W-1:0]     rem_ff,          rem_in;
   logic [DIV_BITS-1:0]    quo_ff,          quo_in;
   logic [STEP_W-1:0]      step_ff,         step_in;
   logic [DIV_BITS-1:0]    fs_ff,           fs_in;
   logic [DEPTH_W-1:0]     new_depth_ff,    new_depth_in;
   logic [RATE_IDX_W-1:0]  rate_idx_ff,     rate_idx_in;
   logic                   updated_ff,      updated_in;
   logic                   rsp_valid_ff,    rsp_valid_in;
   logic                   rsp_sv_ff,       rsp_sv_in;
   logic [RATE_W-1:0]      rsp_rate_ff,     rsp_rate_in;
   logic [DEPTH_W-1:0]     rsp_depth_ff,    rsp_depth_in;
   logic                   rsp_upd_ff,      rsp_upd_in;
   logic                   rsp_fam_ff,      rsp_fam_in;

   // combinational helpers
   logic                   req_take;
   logic                   csr_write;
   logic                   near_w;
   logic                   near_b;
   logic                   changed;
   logic                   zero_count;
   logic [COUNT_W-1:0]     den;
   logic [COUNT_W:0]       shifted;
   logic [COUNT_W+1:0]     diff;
   logic                   ge;
   logic [COUNT_W-1:0]     rem_step;
   logic [DIV_BITS-1:0]    quo_step;
   logic                   div_done;
   logic [DIV_BITS-1:0]    ratio_num;
   logic [DEPTH_W-1:0]     depth_code;
   logic [RATE_W-1:0]      typ;
   logic [RATE_W+TOL_W-1:0] dev_prod;
   logic [DEV_W-1:0]       dev;
   logic                   rate_hit;
   logic                   snap_last;
   logic [RATE_W-1:0]      rate_pick;
   logic                   valid_new;
   logic                   out_free;

   // handshakes
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_TOLERANCE) ?
                       {{(CSR_DW-TOL_W){1'b0}}, tol_ff} : '0;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // closeness to the stored pair
   assign near_w = (wc_ff == last_wc_ff) ||
                   ({1'b0, wc_ff} == {1'b0, last_wc_ff} + (COUNT_W+1)'(1)) ||
                   ({1'b0, last_wc_ff} == {1'b0, wc_ff} + (COUNT_W+1)'(1));
   assign near_b = (bc_ff == last_bc_ff) ||
                   ({1'b0, bc_ff} == {1'b0, last_bc_ff} + (COUNT_W+1)'(1)) ||
                   ({1'b0, last_bc_ff} == {1'b0, bc_ff} + (COUNT_W+1)'(1));
   assign changed    = !near_w || !near_b || !held_valid_ff;
   assign zero_count = (wc_ff == '0) || (bc_ff == '0);

   // shared restoring divider step, one quotient bit per cycle
   assign den      = (state_ff == ST_DIV_RATE) ? wc_ff : bc_ff;
   assign shifted  = {rem_ff, quo_ff[DIV_BITS-1]};
   assign diff     = {1'b0, shifted} - {2'b00, den};
   assign ge       = !diff[COUNT_W+1];
   assign rem_step = ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
   assign quo_step = {quo_ff[DIV_BITS-2:0], ge};
   assign div_done = (step_ff == STEP_W'(1));

   assign ratio_num = DIV_BITS'(wc_ff) * DIV_BITS'(BIT_RATIO);

   // rounded ratio of 16, 24 or 32 from the truncated quotient
   always_comb begin
      depth_code = DEPTH_NONE;
      if ((quo_step == DIV_BITS'(31)) || (quo_step == DIV_BITS'(32))) begin
         depth_code = DEPTH_16;
      end else if ((quo_step == DIV_BITS'(47)) || (quo_step == DIV_BITS'(48))) begin
         depth_code = DEPTH_24;
      end else if ((quo_step == DIV_BITS'(63)) || (quo_step == DIV_BITS'(64))) begin
         depth_code = DEPTH_32;
      end
   end

   // window test against one standard rate per cycle
   assign typ       = STD_RATE[rate_idx_ff];
   assign dev_prod  = {{TOL_W{1'b0}}, typ} * {{RATE_W{1'b0}}, tol_ff};
   assign dev       = dev_prod[RATE_W+TOL_W-1:PPM_SHIFT];
   assign rate_hit  = (CMP_W'(fs_ff) <= CMP_W'(typ) + CMP_W'(dev)) &&
                      (CMP_W'(fs_ff) + CMP_W'(dev) >= CMP_W'(typ));
   assign snap_last = rate_hit || (rate_idx_ff == RATE_IDX_W'(NUM_STD_RATES - 1));
   assign rate_pick = rate_hit ? typ : '0;
   assign valid_new = (rate_pick != '0) && (new_depth_ff != DEPTH_NONE) &&
                      (rate_pick == held_rate_ff) && (new_depth_ff == held_depth_ff);

   // sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      wc_in         = wc_ff;
      bc_in         = bc_ff;
      last_wc_in    = last_wc_ff;
      last_bc_in    = last_bc_ff;
      held_rate_in  = held_rate_ff;
      held_depth_in = held_depth_ff;
      held_valid_in = held_valid_ff;
      tol_in        = tol_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      fs_in         = fs_ff;
      new_depth_in  = new_depth_ff;
      rate_idx_in   = rate_idx_ff;
      updated_in    = updated_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sv_in     = rsp_sv_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_upd_in    = rsp_upd_ff;
      rsp_fam_in    = rsp_fam_ff;

      // tolerance register write
      if (csr_write && (csr_paddr[2] == CSR_TOLERANCE)) begin
         tol_in = csr_pwdata[TOL_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               wc_in    = req_word_clock_count & COUNT_MASK;
               bc_in    = req_bit_clock_count & COUNT_MASK;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            updated_in = 1'b0;
            if (!changed) begin
               state_in = ST_FINISH;
            end else if (zero_count) begin
               held_valid_in = 1'b0;
               state_in      = ST_FINISH;
            end else begin
               last_wc_in = wc_ff;
               last_bc_in = bc_ff;
               rem_in     = '0;
               quo_in     = RATE_NUM[DIV_BITS-1:0];
               step_in    = STEP_W'(DIV_BITS);
               state_in   = ST_DIV_RATE;
            end
         end
         ST_DIV_RATE: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff - STEP_W'(1);
            if (div_done) begin
               fs_in    = quo_step;
               rem_in   = '0;
               quo_in   = ratio_num;
               step_in  = STEP_W'(DIV_BITS);
               state_in = ST_DIV_DEPTH;
            end
         end
         ST_DIV_DEPTH: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff - STEP_W'(1);
            if (div_done) begin
               new_depth_in = depth_code;
               rate_idx_in  = '0;
               state_in     = ST_SNAP;
            end
         end
         ST_SNAP: begin
            if (snap_last) begin
               updated_in    = valid_new && !held_valid_ff;
               held_rate_in  = rate_pick;
               held_depth_in = new_depth_ff;
               held_valid_in = valid_new;
               state_in      = ST_FINISH;
            end else begin
               rate_idx_in = rate_idx_ff + RATE_IDX_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sv_in    = held_valid_ff;
               rsp_rate_in  = held_rate_ff;
               rsp_depth_in = held_depth_ff;
               rsp_upd_in   = updated_ff;
               rsp_fam_in   = is_family_48k(held_rate_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_wc_ff    <= '0;
         last_bc_ff    <= '0;
         held_rate_ff  <= '0;
         held_depth_ff <= '0;
         held_valid_ff <= 1'b0;
         tol_ff        <= TOL_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_wc_ff    <= last_wc_in;
         last_bc_ff    <= last_bc_in;
         held_rate_ff  <= held_rate_in;
         held_depth_ff <= held_depth_in;
         held_valid_ff <= held_valid_in;
         tol_ff        <= tol_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      wc_ff        <= wc_in;
      bc_ff        <= bc_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      fs_ff        <= fs_in;
      new_depth_ff <= new_depth_in;
      rate_idx_ff  <= rate_idx_in;
      updated_ff   <= updated_in;
      rsp_sv_ff    <= rsp_sv_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_upd_ff   <= rsp_upd_in;
      rsp_fam_ff   <= rsp_fam_in;
   end

   // response outputs
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_stream_valid    = rsp_sv_ff;
   assign rsp_sample_rate_hz  = rsp_rate_ff;
   assign rsp_frame_bit_depth = rsp_depth_ff;
   assign rsp_lock_pulse      = rsp_upd_ff;
   assign rsp_family_48k      = rsp_fam_ff;

   // assertions
   `ACFD_ASSERT(a_upd_implies_valid, clock, reset, !(rsp_valid_ff && rsp_upd_ff) || rsp_sv_ff, "lock pulse without stream_valid")
   `ACFD_ASSERT(a_valid_has_format, clock, reset, !(rsp_valid_ff && rsp_sv_ff) || ((rsp_rate_ff != '0) && (rsp_depth_ff != DEPTH_NONE)), "stream_valid with unknown rate or depth")
   `ACFD_ASSERT_NEXT(a_take_to_check, clock, reset, req_valid && !req_stall, state_ff == ST_CHECK, "accepted transaction did not enter check")
   `ACFD_ASSERT(a_rem_below_den, clock, reset, !((state_ff == ST_DIV_RATE) || (state_ff == ST_DIV_DEPTH)) || (rem_ff < den), "divider remainder not below divisor")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// This bench drives word and bit clock measurement pairs into the audio clock
// format detector and checks every response. The checks cover rate snapping,
// slot depth rounding, the hold of a stable format, the update pulse and the
// tolerance register. A predictor in the bench keeps its own copy of the
// detector state and queues one expected format per accepted request. Both
// channels idle and stall at random. The tolerance is reprogrammed only
// between phases, once all responses have drained.
// ---------------------------------------------------------------------------
module testbench;

   import acfd_pkg::*;

   // detector parameters, same as the defaults of the block
   localparam int CLOCK_HZ    = 125000000;
   localparam int WORD_WINDOW = 24;
   localparam int BIT_RATIO   = 32;
   localparam int COUNT_BITS  = 24;

   // (CLOCK_HZ / 2) * WORD_WINDOW, divided by the word count gives the rate
   localparam longint unsigned TICK_RATE_PRODUCT =
      64'(CLOCK_HZ / 2) * 64'(WORD_WINDOW);

   localparam int TOLERANCE_BYTE_ADDR = 4 * int'(CSR_TOLERANCE);
   localparam int SETTLE_CYCLES       = 8;
   localparam int LATENCY_CYCLES      = 80;
   localparam int WATCHDOG_LIMIT      = 20000;
   localparam int MAX_REPORTS         = 10;

   typedef struct packed {
      logic               stream_valid;
      logic [RATE_W-1:0]  sample_rate_hz;
      logic [DEPTH_W-1:0] frame_bit_depth;
      logic               lock_pulse;
      logic               family_48k;
   } format_result_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [COUNT_W-1:0]   req_word_clock_count;
   logic [COUNT_W-1:0]   req_bit_clock_count;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_stream_valid;
   logic [RATE_W-1:0]    rsp_sample_rate_hz;
   logic [DEPTH_W-1:0]   rsp_frame_bit_depth;
   logic                 rsp_lock_pulse;
   logic                 rsp_family_48k;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [CSR_AW-1:0]    csr_paddr;
   logic [CSR_DW-1:0]    csr_pwdata;
   logic [CSR_DW-1:0]    csr_prdata;
   logic                 csr_pready;

   // predictor copy of the detector state
   logic [COUNT_W-1:0]   seen_word_count;
   logic [COUNT_W-1:0]   seen_bit_count;
   logic [RATE_W-1:0]    kept_rate_hz;
   logic [DEPTH_W-1:0]   kept_depth;
   logic                 kept_valid;
   logic [TOL_W-1:0]     tolerance_setting;

   format_result_type    expected_formats[$];
   format_result_type    oldest_format;
   int unsigned          mismatch_count = 0;
   int unsigned          items_sent = 0;
   int unsigned          idle_cycles = 0;
   logic                 calm_stretch = 1'b0;
   int unsigned          stall_run = 0;
   int unsigned          stall_roll;

   audio_clock_format_detector #(
      .CLOCK_HZ    (CLOCK_HZ),
      .WORD_WINDOW (WORD_WINDOW),
      .BIT_RATIO   (BIT_RATIO),
      .COUNT_BITS  (COUNT_BITS)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_word_clock_count (req_word_clock_count),
      .req_bit_clock_count  (req_bit_clock_count),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_stream_valid     (rsp_stream_valid),
      .rsp_sample_rate_hz   (rsp_sample_rate_hz),
      .rsp_frame_bit_depth  (rsp_frame_bit_depth),
      .rsp_lock_pulse       (rsp_lock_pulse),
      .rsp_family_48k       (rsp_family_48k),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // standard rates in the order they are tried
   function automatic int unsigned nominal_rate(input int idx);
      case (idx)
         0:       return 384000;
         1:       return 352800;
         2:       return 192000;
         3:       return 176400;
         4:       return 96000;
         5:       return 88200;
         6:       return 48000;
         default: return 44100;
      endcase
   endfunction

   function automatic logic within_one_tick(input logic [COUNT_W-1:0] a,
                                            input logic [COUNT_W-1:0] b);
      return (a >= b) ? ((a - b) <= 1) : ((b - a) <= 1);
   endfunction

   // first standard rate whose tolerance window holds the measured rate
   function automatic logic [RATE_W-1:0] snap_to_standard(input longint unsigned fs);
      longint unsigned typ;
      longint unsigned dev;
      for (int i = 0; i < NUM_STD_RATES; i++) begin
         typ = longint'(nominal_rate(i));
         dev = (typ * longint'(tolerance_setting)) >> PPM_SHIFT;
         if (fs <= typ + dev && fs + dev >= typ) begin
            return RATE_W'(typ);
         end
      end
      return '0;
   endfunction

   // expected response for one measurement pair, advances the predictor state
   function automatic format_result_type predict_format(input logic [COUNT_W-1:0] wc,
                                                        input logic [COUNT_W-1:0] bc);
      format_result_type res;
      longint unsigned fs;
      longint unsigned ratio;
      logic [RATE_W-1:0]  rate;
      logic [DEPTH_W-1:0] slot_depth;
      logic            valid_now;
      res = '0;
      if (!within_one_tick(wc, seen_word_count) || !within_one_tick(bc, seen_bit_count) ||
          !kept_valid) begin
         if (wc == '0 || bc == '0) begin
            kept_valid = 1'b0;
         end else begin
            seen_word_count = wc;
            seen_bit_count  = bc;
            fs    = TICK_RATE_PRODUCT / longint'(wc);
            rate  = snap_to_standard(fs);
            ratio = ((64'(BIT_RATIO) * longint'(wc)) / longint'(bc) + 1) >> 1;
            if (ratio == 64'(DEPTH_16) || ratio == 64'(DEPTH_24) || ratio == 64'(DEPTH_32)) begin
               slot_depth = ratio[DEPTH_W-1:0];
            end else begin
               slot_depth = DEPTH_NONE;
            end
            valid_now = rate != '0 && slot_depth != DEPTH_NONE &&
                        rate == kept_rate_hz && slot_depth == kept_depth;
            res.lock_pulse = valid_now && !kept_valid;
            kept_rate_hz = rate;
            kept_depth   = slot_depth;
            kept_valid   = valid_now;
         end
      end
      res.stream_valid    = kept_valid;
      res.sample_rate_hz  = kept_rate_hz;
      res.frame_bit_depth = kept_depth;
      res.family_48k      = kept_rate_hz == RATE_W'(48000) || kept_rate_hz == RATE_W'(96000) ||
                            kept_rate_hz == RATE_W'(192000) || kept_rate_hz == RATE_W'(384000);
      return res;
   endfunction

   task automatic report_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   task automatic check_field(input string field_name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         report_failure($sformatf("mismatch in %s: expected %0d, actual %0d",
                                  field_name, want, got));
      end
   endtask

   // mostly short gaps, a few long ones, none during a calm stretch
   function automatic int unsigned next_idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm_stretch) begin
         return 0;
      end else if (roll < 50) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(30, 100);
   endfunction

   // one request transaction, then an idle gap
   task automatic send_measurement(input logic [COUNT_W-1:0] wc, input logic [COUNT_W-1:0] bc);
      int unsigned gap;
      req_valid            <= 1'b1;
      req_word_clock_count <= wc;
      req_bit_clock_count  <= bc;
      do @(posedge clock); while (req_stall);
      expected_formats.push_back(predict_format(wc, bc));
      items_sent++;
      gap = next_idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // a plausible clock format held for a while, with jitter and dropouts
   task automatic send_format_burst(input int unsigned length);
      int base_wc;
      int base_bc;
      int wc;
      int bc;
      int slot;
      case ($urandom_range(0, 3))
         0:       slot = 16;
         1:       slot = 24;
         2:       slot = 32;
         default: slot = $urandom_range(8, 40);
      endcase
      base_wc = int'(TICK_RATE_PRODUCT / longint'(nominal_rate($urandom_range(0, 7))));
      base_wc = base_wc + int'($urandom_range(0, 8)) - 4;
      base_bc = (16 * base_wc) / slot + int'($urandom_range(0, 2)) - 1;
      repeat (length) begin
         wc = base_wc;
         bc = base_bc;
         case ($urandom_range(0, 9))
            0, 1: wc = base_wc + int'($urandom_range(0, 2)) - 1;
            2:    bc = base_bc + int'($urandom_range(0, 2)) - 1;
            3:    wc = base_wc + int'($urandom_range(2, 5));
            4: begin
               if ($urandom_range(0, 3) == 0) begin
                  if ($urandom_range(0, 1) == 0) wc = 0;
                  else bc = 0;
               end
            end
            default: ;
         endcase
         send_measurement(COUNT_W'(wc), COUNT_W'(bc));
      end
   endtask

   // arbitrary pairs, mostly outside any standard format
   task automatic send_noise_measurement();
      logic [COUNT_W-1:0] wc;
      logic [COUNT_W-1:0] bc;
      wc = COUNT_W'($urandom);
      bc = COUNT_W'($urandom);
      case ($urandom_range(0, 4))
         0: begin
            wc = COUNT_W'($urandom_range(3000, 40000));
            bc = COUNT_W'($urandom_range(int'(wc) / 4, int'(wc) * 2));
         end
         1: bc = COUNT_W'($urandom_range(1, 64));
         2: begin
            if ($urandom_range(0, 1) == 0) wc = '0;
            else bc = '0;
         end
         default: ;
      endcase
      send_measurement(wc, bc);
   endtask

   // lower valid and wait until every expected response has come back
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_formats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one csr transfer: setup phase, access phase, then back to idle
   task automatic csr_transfer(input logic is_write, input logic [CSR_DW-1:0] wdata,
                               output logic [CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= TOLERANCE_BYTE_ADDR[CSR_AW-1:0];
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // write the tolerance with junk in the upper bits, then read it back
   task automatic program_tolerance(input logic [TOL_W-1:0] value);
      logic [CSR_DW-1:0] readback;
      wait_until_idle();
      csr_transfer(1'b1, {CSR_DW'($urandom) & ~CSR_DW'({TOL_W{1'b1}})} | CSR_DW'(value),
                   readback);
      tolerance_setting = value;
      csr_transfer(1'b0, '0, readback);
      check_field("tolerance readback", tolerance_setting, readback[TOL_W-1:0]);
   endtask

   task automatic test_register_reset();
      logic [CSR_DW-1:0] readback;
      csr_transfer(1'b0, '0, readback);
      check_field("tolerance after reset", TOL_RESET, readback[TOL_W-1:0]);
   endtask

   // field extremes, each standard rate and depth, hold, dropout and rounding
   task automatic test_directed_formats();
      send_measurement(24'd0, 24'd0);
      send_measurement(24'hFFFFFF, 24'd0);
      send_measurement(24'd0, 24'hFFFFFF);
      send_measurement(24'hFFFFFF, 24'hFFFFFF);
      send_measurement(24'd1, 24'hFFFFFF);
      send_measurement(24'hFFFFFF, 24'd1);
      // 48 khz, 32 bit slots: first pass stores, second validates
      send_measurement(24'd31250, 24'd15625);
      send_measurement(24'd31250, 24'd15625);
      send_measurement(24'd31250, 24'd15625);
      // one tick of drift is ignored, two ticks recompute
      send_measurement(24'd31251, 24'd15624);
      send_measurement(24'd31252, 24'd15625);
      // dropout, then recovery pulses the update again
      send_measurement(24'd0, 24'd15625);
      send_measurement(24'd31252, 24'd15625);
      // 44.1 khz 24 bit, 192 khz 16 bit, 384 khz 32 bit
      send_measurement(24'd34013, 24'd22675);
      send_measurement(24'd34013, 24'd22675);
      send_measurement(24'd7812, 24'd7812);
      send_measurement(24'd7812, 24'd7812);
      send_measurement(24'd3906, 24'd1953);
      send_measurement(24'd3906, 24'd1953);
      // remaining rates
      send_measurement(24'd4251, 24'd2125);
      send_measurement(24'd8503, 24'd8503);
      send_measurement(24'd15625, 24'd10416);
      send_measurement(24'd17006, 24'd8503);
      // depth rounding: ratio 31 rounds to 16, ratio 33 gives no depth
      send_measurement(24'd31250, 24'd32258);
      send_measurement(24'd31250, 24'd30303);
   endtask

   // zero and full tolerance, then a few in between
   task automatic test_tolerance_extremes();
      logic [TOL_W-1:0] settings [4];
      int unsigned      goal;
      settings[0] = '0;
      settings[1] = '1;
      settings[2] = TOL_W'(1);
      settings[3] = TOL_W'($urandom_range(0, 4095));
      foreach (settings[i]) begin
         program_tolerance(settings[i]);
         goal = items_sent + 120;
         while (items_sent < goal) begin
            send_format_burst($urandom_range(2, 8));
         end
      end
   endtask

   // mixed bursts and noise at the reset tolerance and a random one
   task automatic test_random_traffic();
      int unsigned goal;
      program_tolerance(TOL_RESET);
      goal = items_sent + 260;
      while (items_sent < goal) begin
         if ($urandom_range(0, 9) < 7) send_format_burst($urandom_range(2, 8));
         else repeat ($urandom_range(1, 3)) send_noise_measurement();
      end
      program_tolerance(TOL_W'($urandom_range(100, 2000)));
      goal = items_sent + 260;
      while (items_sent < goal) begin
         if ($urandom_range(0, 9) < 7) send_format_burst($urandom_range(2, 8));
         else repeat ($urandom_range(1, 3)) send_noise_measurement();
      end
   endtask

   // back to back requests with the response side never stalled
   task automatic test_back_to_back();
      int unsigned goal;
      calm_stretch <= 1'b1;
      goal = items_sent + 130;
      while (items_sent < goal) begin
         if ($urandom_range(0, 4) != 0) send_format_burst($urandom_range(2, 6));
         else send_noise_measurement();
      end
      calm_stretch <= 1'b0;
   endtask

   // response stalls: mostly short runs, a few long ones
   always @(posedge clock) begin
      if (calm_stretch) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if (stall_run == 0) begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 55) begin
            rsp_stall <= 1'b0;
            stall_run = $urandom_range(1, 24);
         end else if (stall_roll < 88) begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(1, 4);
         end else if (stall_roll < 98) begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(5, 16);
         end else begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(40, 150);
         end
      end else begin
         stall_run = stall_run - 1;
      end
   end

   // compare each response transaction with the oldest expected format
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_formats.size() == 0) begin
            report_failure("response transaction with nothing expected");
         end else begin
            oldest_format = expected_formats.pop_front();
            check_field("stream_valid", oldest_format.stream_valid, rsp_stream_valid);
            check_field("sample_rate_hz", oldest_format.sample_rate_hz, rsp_sample_rate_hz);
            check_field("frame_bit_depth", oldest_format.frame_bit_depth, rsp_frame_bit_depth);
            check_field("lock_pulse", oldest_format.lock_pulse, rsp_lock_pulse);
            check_field("family_48k", oldest_format.family_48k, rsp_family_48k);
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("testbench failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // test sequence
   initial begin
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_word_clock_count <= '0;
      req_bit_clock_count  <= '0;
      rsp_stall            <= 1'b0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      seen_word_count   = '0;
      seen_bit_count    = '0;
      kept_rate_hz      = '0;
      kept_depth        = DEPTH_NONE;
      kept_valid        = 1'b0;
      tolerance_setting = TOL_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_reset();
      test_directed_formats();
      test_tolerance_extremes();
      test_random_traffic();
      test_back_to_back();

      wait_until_idle();
      repeat (LATENCY_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
